FILE: src/wrr_pkg.sv
// Shared types, codes and helpers for the weighted round-robin thread table.
`default_nettype none

package wrr_pkg;

	localparam int MAX_THREADS_DEF = 12;

	// Event codes
	localparam logic [1:0] CMD_CREATE = 2'd0;
	localparam logic [1:0] CMD_TICK   = 2'd1;
	localparam logic [1:0] CMD_SWITCH = 2'd2;
	localparam logic [1:0] CMD_EXIT   = 2'd3;

	// Status codes
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	// Register file
	localparam int              APB_AW        = 3;
	localparam logic [APB_AW-1:0] ADDR_QUANTUM = '0;
	localparam logic [7:0]      QUANTUM_RESET = 8'd1;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [31:0] context_sp;
	} in_word_t;

	typedef struct packed {
		logic [31:0] next_sp;
		logic [9:0]  slice_length;
		logic [3:0]  thread_id;
		logic [31:0] run_count;
		logic [1:0]  status;
		logic        no_threads;
	} out_word_t;

	// One table entry as held in memory
	typedef struct packed {
		logic [31:0] sp;
		logic [3:0]  id;
		logic [31:0] runs;
	} entry_t;

	// Priority 4, 3 or 2 for id mod 3 = 0, 1 or 2
	function automatic logic [2:0] prio_of(input logic [3:0] id);
		logic [2:0] p;
		unique case (id)
			4'd0, 4'd3, 4'd6, 4'd9, 4'd12, 4'd15: p = 3'd4;
			4'd1, 4'd4, 4'd7, 4'd10, 4'd13:       p = 3'd3;
			default:                              p = 3'd2;
		endcase
		return p;
	endfunction

endpackage

`default_nettype wire

FILE: src/wrr_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module wrr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

FILE: src/weighted_round_robin_thread_table.sv
// Top level of the weighted round-robin thread table.
//
//  channel   direction  handshake            word
//  in        input      in_valid / in_stall  wrr_pkg::in_word_t (cmd, context_sp)
//  out       output     out_valid/out_stall  wrr_pkg::out_word_t (one per input word)
//  apb       input      psel/penable/pready  quantum_units at byte address 0
//
// Create and any event on an empty table go from idle straight to the result;
// tick and exit read one entry, and a switch reads two entries through the single
// memory port pair and writes them back one after another (one write if top is next).
// Reset clears the entry count, the round-robin slot and the flags; entries
// need no clearing, as only written slots are ever read.
// One word is at work at a time; the output register lets the next word in
// while a result waits on out_stall.
`default_nettype none

module weighted_round_robin_thread_table #(
	parameter int MAX_THREADS = wrr_pkg::MAX_THREADS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire wrr_pkg::in_word_t             in_data,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output wrr_pkg::out_word_t                 out_data,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [wrr_pkg::APB_AW-1:0]    paddr,
	input  wire logic [31:0]                   pwdata,
	output logic [31:0]                        prdata,
	output logic                               pready
);

	localparam int AW = (MAX_THREADS > 1) ? $clog2(MAX_THREADS) : 1;
	localparam int CW = $clog2(MAX_THREADS + 1);
	localparam int EW = $bits(wrr_pkg::entry_t);

	typedef enum logic [2:0] {S_IDLE, S_FIRST, S_SECOND, S_THIRD, S_DONE} state_t;

	state_t             state_q;
	logic [1:0]         cmd_q;
	logic [31:0]        ctx_q;
	logic [AW-1:0]      top_q;
	logic [AW-1:0]      e_q;
	wrr_pkg::entry_t    b_q;
	wrr_pkg::out_word_t res_q;
	wrr_pkg::out_word_t out_q;
	logic               out_valid_q;
	logic [CW-1:0]      total_q;
	logic [CW-1:0]      next_slot_q;
	logic [31:0]        main_sp_q;
	logic               main_cap_q;
	logic               exit_pend_q;
	logic [7:0]         quantum_q;

	logic               in_acc;
	logic [CW-1:0]      top_c;
	logic [CW-1:0]      e_c;
	logic [CW-1:0]      sum_c;
	logic [CW-1:0]      ns_c;
	wrr_pkg::entry_t    rd_entry;
	wrr_pkg::entry_t    a_mod;
	wrr_pkg::entry_t    new_top;
	logic [10:0]        slice_c;
	logic               ram_we;
	logic [AW-1:0]      ram_waddr;
	wrr_pkg::entry_t    ram_wdata;
	logic               ram_re;
	logic [AW-1:0]      ram_raddr;
	logic [EW-1:0]      ram_rdata;

	assign in_stall  = (state_q != S_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign pready    = 1'b1;
	assign prdata    = (paddr == wrr_pkg::ADDR_QUANTUM) ? 32'(quantum_q) : '0;

	assign top_c    = total_q - CW'(1);
	assign e_c      = (next_slot_q < total_q) ? next_slot_q : '0;
	assign rd_entry = wrr_pkg::entry_t'(ram_rdata);
	assign slice_c  = 11'(wrr_pkg::prio_of(rd_entry.id)) * 11'(quantum_q);

	// Round-robin advance over the entries below the top
	assign sum_c = CW'(e_q) + CW'(1);
	always_comb begin
		if (top_q <= AW'(1)) begin
			ns_c = '0;
		end else if (sum_c >= CW'(top_q)) begin
			ns_c = sum_c - CW'(top_q);
		end else begin
			ns_c = sum_c;
		end
	end

	// Top entry with the context saved, and the entry that becomes the top
	always_comb begin
		a_mod = rd_entry;
		if (main_cap_q && !exit_pend_q) begin
			a_mod.sp = ctx_q;
		end
		new_top = (e_q == top_q) ? a_mod : b_q;
		if (new_top.runs != '1) begin
			new_top.runs = new_top.runs + 32'd1;
		end
	end

	// Memory port control
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = top_q;
		ram_wdata = b_q;
		ram_re    = 1'b0;
		ram_raddr = e_c[AW-1:0];
		unique case (state_q)
			S_IDLE: begin
				if (in_acc && total_q != '0) begin
					ram_re    = (in_data.cmd != wrr_pkg::CMD_CREATE);
					ram_raddr = (in_data.cmd == wrr_pkg::CMD_EXIT) ? top_c[AW-1:0]
						: e_c[AW-1:0];
				end
				if (in_acc && in_data.cmd == wrr_pkg::CMD_CREATE
						&& total_q < CW'(MAX_THREADS)) begin
					ram_we    = 1'b1;
					ram_waddr = total_q[AW-1:0];
					ram_wdata = '{sp: in_data.context_sp, id: 4'(total_q), runs: '0};
				end
			end
			S_FIRST: begin
				ram_re    = (cmd_q == wrr_pkg::CMD_SWITCH);
				ram_raddr = top_q;
			end
			S_SECOND: begin
				ram_we = 1'b1;
				if (e_q == top_q) begin
					ram_waddr = top_q;
					ram_wdata = new_top;
				end else begin
					ram_waddr = e_q;
					ram_wdata = a_mod;
				end
			end
			S_THIRD: begin
				ram_we    = 1'b1;
				ram_waddr = top_q;
				ram_wdata = b_q;
			end
			S_DONE: begin
				ram_we = 1'b0;
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	wrr_ram #(
		.WIDTH (EW),
		.DEPTH (MAX_THREADS)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (EW'(ram_wdata)),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			total_q     <= '0;
			next_slot_q <= '0;
			main_cap_q  <= 1'b0;
			exit_pend_q <= 1'b0;
			quantum_q   <= wrr_pkg::QUANTUM_RESET;
		end else begin
			if (psel && penable && pwrite && pready && paddr == wrr_pkg::ADDR_QUANTUM) begin
				quantum_q <= pwdata[7:0];
			end
			if (out_valid_q && !out_stall && state_q != S_DONE) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						cmd_q <= in_data.cmd;
						ctx_q <= in_data.context_sp;
						top_q <= top_c[AW-1:0];
						e_q   <= e_c[AW-1:0];
						if (total_q == '0 && in_data.cmd != wrr_pkg::CMD_CREATE) begin
							res_q <= '{
								next_sp: (in_data.cmd == wrr_pkg::CMD_SWITCH && main_cap_q)
									? main_sp_q : 32'd0,
								slice_length: '0,
								thread_id: '0,
								run_count: '0,
								status: wrr_pkg::ST_EMPTY,
								no_threads: 1'b1
							};
							state_q <= S_DONE;
						end else if (in_data.cmd == wrr_pkg::CMD_CREATE) begin
							if (total_q >= CW'(MAX_THREADS)) begin
								res_q <= '{next_sp: '0, slice_length: '0, thread_id: '0,
									run_count: '0, status: wrr_pkg::ST_FULL, no_threads: 1'b0};
							end else begin
								res_q <= '{next_sp: '0, slice_length: '0,
									thread_id: 4'(total_q), run_count: '0,
									status: wrr_pkg::ST_OK, no_threads: 1'b0};
								total_q <= total_q + CW'(1);
							end
							state_q <= S_DONE;
						end else begin
							res_q   <= '0;
							state_q <= S_FIRST;
						end
					end
				end
				S_FIRST: begin
					unique case (cmd_q)
						wrr_pkg::CMD_TICK: begin
							res_q.slice_length <= slice_c[9:0];
							state_q            <= S_DONE;
						end
						wrr_pkg::CMD_EXIT: begin
							res_q.thread_id  <= rd_entry.id;
							res_q.run_count  <= rd_entry.runs;
							res_q.no_threads <= (total_q == CW'(1));
							total_q          <= total_q - CW'(1);
							exit_pend_q      <= 1'b1;
							state_q          <= S_DONE;
						end
						wrr_pkg::CMD_SWITCH: begin
							b_q     <= rd_entry;
							state_q <= S_SECOND;
						end
						wrr_pkg::CMD_CREATE: begin
							state_q <= S_DONE;
						end
					endcase
				end
				S_SECOND: begin
					// first switch keeps the pointer as the main one; pending exit drops it
					if (!main_cap_q) begin
						main_sp_q  <= ctx_q;
						main_cap_q <= 1'b1;
					end else if (exit_pend_q) begin
						exit_pend_q <= 1'b0;
					end
					next_slot_q     <= ns_c;
					res_q.next_sp   <= new_top.sp;
					res_q.thread_id <= new_top.id;
					res_q.run_count <= new_top.runs;
					b_q             <= new_top;
					state_q         <= (e_q == top_q) ? S_DONE : S_THIRD;
				end
				S_THIRD: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (!out_valid_q || !out_stall) begin
						out_q       <= res_q;
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_total_bound: assert property (@(posedge clk) disable iff (!arst_n)
		total_q <= CW'(MAX_THREADS))
		else $error("thread count above table depth");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> in_stall)
		else $error("word accepted while table update in flight");

	a_main_sp_kept: assert property (@(posedge clk) disable iff (!arst_n)
		!$fell(main_cap_q))
		else $error("main pointer capture lost");

endmodule

`default_nettype wire

FILE: bench/tb_top.sv
`timescale 1ns / 100ps
// Self-checking bench for the weighted round-robin thread table, with a mirrored table model.
module tb_top;

	localparam int TABLE_SLOTS  = 12;
	localparam int PHASE_WORDS  = 325;
	localparam int DRAIN_CYCLES = 10;

	logic                       clk;
	logic                       arst_n;
	logic                       in_valid;
	logic                       in_stall;
	wrr_pkg::in_word_t          in_data;
	logic                       out_valid;
	logic                       out_stall;
	wrr_pkg::out_word_t         out_data;
	logic                       psel;
	logic                       penable;
	logic                       pwrite;
	logic [wrr_pkg::APB_AW-1:0] paddr;
	logic [31:0]                pwdata;
	logic [31:0]                prdata;
	logic                       pready;

	int unsigned idle_pct  = 0;
	int unsigned stall_pct = 0;

	class thread_table_mirror;
		typedef struct packed {
			logic [31:0] sp;
			logic [3:0]  id;
			logic [2:0]  weight;
			logic [31:0] runs;
		} slot_t;

		slot_t              entries[TABLE_SLOTS];
		int unsigned        count;
		int unsigned        rr_slot;
		logic [31:0]        main_sp;
		bit                 main_held;
		bit                 exit_held;
		logic [7:0]         quantum;
		wrr_pkg::out_word_t replies_due[$];
		int                 errors;

		function new();
			count     = 0;
			rr_slot   = 0;
			main_sp   = '0;
			main_held = 1'b0;
			exit_held = 1'b0;
			quantum   = wrr_pkg::QUANTUM_RESET;
			errors    = 0;
		endfunction

		function logic [2:0] weight_of(int unsigned id);
			case (id % 3)
				0: return 3'd4;
				1: return 3'd3;
				default: return 3'd2;
			endcase
		endfunction

		// Advance the mirrored table by one accepted word and queue its reply.
		function void apply_event(wrr_pkg::in_word_t w);
			wrr_pkg::out_word_t r;
			slot_t              tmp;
			int unsigned        top;
			int unsigned        pick;
			r    = '0;
			pick = (rr_slot < count) ? rr_slot : 0;
			case (w.cmd)
				wrr_pkg::CMD_CREATE: begin
					if (count >= TABLE_SLOTS) begin
						r.status = wrr_pkg::ST_FULL;
					end else begin
						entries[count] = '{sp: w.context_sp, id: 4'(count),
							weight: weight_of(count), runs: '0};
						r.thread_id = 4'(count);
						count++;
					end
				end
				wrr_pkg::CMD_TICK: begin
					if (count == 0)
						r.status = wrr_pkg::ST_EMPTY;
					else
						r.slice_length = 10'(int'(entries[pick].weight) * int'(quantum));
				end
				wrr_pkg::CMD_SWITCH: begin
					if (count == 0) begin
						r.next_sp = main_held ? main_sp : '0;
						r.status  = wrr_pkg::ST_EMPTY;
					end else begin
						top = count - 1;
						if (!main_held) begin
							main_sp   = w.context_sp;
							main_held = 1'b1;
						end else if (!exit_held) begin
							entries[top].sp = w.context_sp;
						end else begin
							exit_held = 1'b0;
						end
						tmp           = entries[top];
						entries[top]  = entries[pick];
						entries[pick] = tmp;
						rr_slot = (top == 0) ? 0 : (pick + 1) % top;
						if (entries[top].runs != '1)
							entries[top].runs++;
						r.next_sp   = entries[top].sp;
						r.thread_id = entries[top].id;
						r.run_count = entries[top].runs;
					end
				end
				default: begin
					if (count == 0) begin
						r.status = wrr_pkg::ST_EMPTY;
					end else begin
						top         = count - 1;
						r.thread_id = entries[top].id;
						r.run_count = entries[top].runs;
						count       = top;
						exit_held   = 1'b1;
					end
				end
			endcase
			r.no_threads = (count == 0);
			replies_due.push_back(r);
		endfunction

		function void compare(string name, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				$display("%0t: %s expected %h got %h", $time, name, want, got);
				errors++;
			end
		endfunction

		function void match_reply(wrr_pkg::out_word_t got);
			wrr_pkg::out_word_t want;
			if (replies_due.size() == 0) begin
				$display("%0t: reply with none pending, expected nothing got %h", $time, got);
				errors++;
				return;
			end
			want = replies_due.pop_front();
			compare("next_sp", want.next_sp, got.next_sp);
			compare("slice_length", 32'(want.slice_length), 32'(got.slice_length));
			compare("thread_id", 32'(want.thread_id), 32'(got.thread_id));
			compare("run_count", want.run_count, got.run_count);
			compare("status", 32'(want.status), 32'(got.status));
			compare("no_threads", 32'(want.no_threads), 32'(got.no_threads));
		endfunction
	endclass

	thread_table_mirror board = new();

	weighted_round_robin_thread_table dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#(5_000_000);
		$display("tb_top failed");
		$finish;
	end

	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			out_stall = ($urandom_range(99) < stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			board.match_reply(out_data);
	end

	function automatic logic [31:0] pick_sp();
		int unsigned roll;
		roll = $urandom_range(9);
		if (roll == 0)
			return '0;
		if (roll == 1)
			return '1;
		return $urandom();
	endfunction

	// Write the quantum, then read it back.
	task automatic set_quantum(input logic [7:0] q);
		@(negedge clk);
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = 1'b1;
		paddr   = wrr_pkg::ADDR_QUANTUM;
		pwdata  = {24'd0, q};
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		board.quantum = q;
		@(negedge clk);
		penable = 1'b0;
		pwrite  = 1'b0;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== {24'd0, q}) begin
			$display("%0t: quantum_units expected %h got %h", $time, {24'd0, q}, prdata);
			board.errors++;
		end
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
	endtask

	task automatic send_word(input logic [1:0] cmd, input logic [31:0] sp);
		@(negedge clk);
		while ($urandom_range(99) < idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		in_data  = '{cmd: cmd, context_sp: sp};
		do @(posedge clk); while (in_stall);
		board.apply_event(in_data);
	endtask

	// Drop valid and wait out every pending reply.
	task automatic settle();
		@(negedge clk);
		in_valid = 1'b0;
		while (board.replies_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic run_phase(input int unsigned idle, input int unsigned stall,
			input logic [7:0] q);
		int unsigned target;
		int unsigned roll;
		logic [1:0]  cmd;
		idle_pct  = idle;
		stall_pct = stall;
		set_quantum(q);
		target = $urandom_range(TABLE_SLOTS + 1);
		for (int n = 0; n < PHASE_WORDS; n++) begin
			// drift the population so the table fills, empties and overflows
			if ($urandom_range(39) == 0)
				target = $urandom_range(TABLE_SLOTS + 1);
			roll = $urandom_range(99);
			if (roll < 25)
				cmd = wrr_pkg::CMD_TICK;
			else if (roll < 55)
				cmd = wrr_pkg::CMD_SWITCH;
			else if (board.count < target)
				cmd = wrr_pkg::CMD_CREATE;
			else if (board.count > target)
				cmd = wrr_pkg::CMD_EXIT;
			else
				cmd = roll[0] ? wrr_pkg::CMD_CREATE : wrr_pkg::CMD_EXIT;
			// an empty switch before the main pointer is held has no defined reply
			if (cmd == wrr_pkg::CMD_SWITCH && board.count == 0 && !board.main_held)
				cmd = wrr_pkg::CMD_CREATE;
			send_word(cmd, pick_sp());
		end
		settle();
	endtask

	initial begin
		arst_n   = 1'b0;
		in_valid = 1'b0;
		in_data  = '0;
		psel     = 1'b0;
		penable  = 1'b0;
		pwrite   = 1'b0;
		paddr    = '0;
		pwdata   = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		set_quantum(8'hFF);
		send_word(wrr_pkg::CMD_TICK, '1);
		send_word(wrr_pkg::CMD_EXIT, '0);
		send_word(wrr_pkg::CMD_CREATE, '0);
		send_word(wrr_pkg::CMD_CREATE, '1);
		send_word(wrr_pkg::CMD_EXIT, 32'h0000_FFFF);
		// capture main while an exit is pending; the flag survives
		send_word(wrr_pkg::CMD_SWITCH, 32'hA5A5_5A5A);
		send_word(wrr_pkg::CMD_SWITCH, 32'h1234_5678);
		send_word(wrr_pkg::CMD_SWITCH, 32'hFFFF_0000);
		send_word(wrr_pkg::CMD_TICK, '0);
		send_word(wrr_pkg::CMD_EXIT, '0);
		send_word(wrr_pkg::CMD_SWITCH, 32'h5A5A_A5A5);
		for (int k = 0; k < TABLE_SLOTS; k++)
			send_word(wrr_pkg::CMD_CREATE, pick_sp());
		send_word(wrr_pkg::CMD_CREATE, '1);
		send_word(wrr_pkg::CMD_TICK, '1);
		send_word(wrr_pkg::CMD_SWITCH, pick_sp());
		send_word(wrr_pkg::CMD_SWITCH, pick_sp());
		send_word(wrr_pkg::CMD_EXIT, '0);
		send_word(wrr_pkg::CMD_SWITCH, pick_sp());
		settle();

		run_phase(0, 0, 8'd0);
		run_phase(75, 0, 8'd1);
		run_phase(0, 75, 8'hFF);
		run_phase(10, 10, 8'($urandom_range(254, 2)));

		if (board.errors == 0 && board.replies_due.size() == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end

endmodule
